/* rtl/ffca_pkg.sv */
// Shared types, constants and helpers for the first-fit coalescing arena allocator.
package ffca_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int HEADER_BYTES_DEF = 48;
  localparam int ALIGN_BYTES_DEF  = 16;
  localparam int ARENA_BYTES_DEF  = 65536;
  localparam int MIN_SPLIT_BYTES  = 8;
  localparam int ARENA_FLOOR      = 64;
  localparam int ARENA_RESET      = 65536;

  localparam int SZW = 17;
  localparam int OFW = 16;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_FLUSH   = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_BADREL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [SZW-1:0] start;
    logic [SZW-1:0] total;
    logic           used;
  } ent_t;

  typedef struct packed {
    status_e        status;
    logic [OFW-1:0] offset;
    logic [SZW-1:0] granted;
  } res_t;

  function automatic logic [SZW-1:0] usable_of(logic [SZW-1:0] total, logic [SZW-1:0] hdr);
    logic [SZW-1:0] r;
    r = (total > hdr) ? total - hdr : '0;
    return r;
  endfunction

endpackage

/* rtl/ffca_mem.sv */
// Segment table memory: one write port, one registered read port.
module ffca_mem import ffca_pkg::*; #(
  parameter int DEPTH = MAX_SEGMENTS_DEF,
  parameter int AW    = $clog2(MAX_SEGMENTS_DEF)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  ent_t          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output ent_t          rdata_o
);

  ent_t mem_q [DEPTH];
  ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ffca_ctrl.sv */
// Sequencer: table scan, split with shift-up, release with merge and shift-down, flush.
module ffca_ctrl import ffca_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF,
  parameter int AW           = $clog2(MAX_SEGMENTS_DEF),
  parameter int CW           = $clog2(MAX_SEGMENTS_DEF + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_init_i,
  input  logic [SZW-1:0] arena_i,
  input  logic           in_go_i,
  input  logic [1:0]     mode_i,
  input  logic [SZW-1:0] req_i,
  input  logic [OFW-1:0] roff_i,
  output logic           idle_o,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output res_t           res_o,
  output logic           we_o,
  output logic [AW-1:0]  waddr_o,
  output ent_t           wdata_o,
  output logic [AW-1:0]  raddr_o,
  input  ent_t           rdata_i
);

  localparam int RSH = 24;
  localparam int NW  = SZW + 1;
  localparam logic [RSH:0] RECIP = (RSH+1)'(((1 << RSH) + ALIGN_BYTES - 1) / ALIGN_BYTES);
  localparam logic [SZW-1:0] HDR = SZW'(HEADER_BYTES);
  localparam logic [NW:0] SPLIT_OVH = (NW+1)'(HEADER_BYTES + MIN_SPLIT_BYTES);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);
  localparam logic [CW-1:0] CNT_TWO = CW'(2);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV1  = 4'd1;
  localparam logic [3:0] S_DIV2  = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_UP    = 4'd4;
  localparam logic [3:0] S_INS_A = 4'd5;
  localparam logic [3:0] S_INS_B = 4'd6;
  localparam logic [3:0] S_R_NX  = 4'd7;
  localparam logic [3:0] S_R_PV  = 4'd8;
  localparam logic [3:0] S_R_FIX = 4'd9;
  localparam logic [3:0] S_DN    = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0]     state_q, state_d;
  logic [1:0]     mode_q, mode_d;
  logic [SZW-1:0] req_q, req_d;
  logic [OFW-1:0] roff_q, roff_d;
  logic [NW-1:0]  quo_q, quo_d;
  logic [NW-1:0]  alloc_q, alloc_d;
  logic [CW-1:0]  i_q, i_d, f_q, f_d, j_q, j_d, cnt_q, cnt_d, k_q, k_d;
  logic           init_q, init_d, rdz_q;
  ent_t           cur_q, cur_d, nx_q, nx_d, pv_q, pv_d;
  logic           nxf_q, nxf_d, pvf_q, pvf_d;
  res_t           res_q, res_d;

  ent_t           e;
  logic [NW-1:0]  num;
  logic [NW+RSH:0] prod;
  logic [NW+6:0]  back;
  logic [SZW-1:0] use_e;
  logic [SZW-1:0] head;
  logic           hit;
  logic           split;
  logic [CW-1:0]  i_nx, j_nx, f_nx, f_pv;

  assign e = (init_q && rdz_q) ? '{start: '0, total: arena_i, used: 1'b0} : rdata_i;
  assign num   = NW'(req_q) + NW'(ALIGN_BYTES - 1);
  assign prod  = (NW+RSH+1)'(num) * (NW+RSH+1)'(RECIP);
  assign back  = (NW+7)'(quo_q) * (NW+7)'(ALIGN_BYTES);
  assign use_e = usable_of(e.total, HDR);
  assign head  = HDR + SZW'(alloc_q);
  assign i_nx  = i_q + CNT_ONE;
  assign j_nx  = j_q + CNT_ONE;
  assign f_nx  = f_q + CNT_ONE;
  assign f_pv  = f_q - CNT_ONE;
  assign hit   = (mode_q == MODE_ALLOC) ? (!e.used && use_e >= req_q)
                                        : (e.used && e.start == {1'b0, roff_q});
  assign split = ((NW+1)'(alloc_q) + SPLIT_OVH <= (NW+1)'(use_e)) && (cnt_q < CNT_MAX);

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    req_d   = req_q;
    roff_d  = roff_q;
    quo_d   = quo_q;
    alloc_d = alloc_q;
    i_d     = i_q;
    f_d     = f_q;
    j_d     = j_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    init_d  = init_q;
    cur_d   = cur_q;
    nx_d    = nx_q;
    pv_d    = pv_q;
    nxf_d   = nxf_q;
    pvf_d   = pvf_q;
    res_d   = res_q;
    we_o    = 1'b0;
    waddr_o = '0;
    wdata_o = '0;
    raddr_o = '0;
    idle_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        idle_o = 1'b1;
        if (cfg_init_i) begin
          init_d = 1'b1;
          cnt_d  = CNT_ONE;
        end
        if (in_go_i) begin
          mode_d = mode_i;
          req_d  = req_i;
          roff_d = roff_i;
          i_d    = '0;
          case (mode_i)
            MODE_ALLOC: state_d = S_DIV1;
            MODE_RELEASE: state_d = S_CHK;
            MODE_FLUSH: begin
              init_d  = 1'b1;
              cnt_d   = CNT_ONE;
              res_d   = '{status: STAT_OK, offset: '0, granted: usable_of(arena_i, HDR)};
              state_d = S_DONE;
            end
            default: begin
              res_d   = '{status: STAT_OK, offset: '0, granted: '0};
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_DIV1: begin
        quo_d   = prod[RSH +: NW];
        state_d = S_DIV2;
      end
      S_DIV2: begin
        alloc_d = (back > (NW+7)'(num)) ? NW'(back - (NW+7)'(ALIGN_BYTES)) : NW'(back);
        state_d = S_CHK;
      end
      S_CHK: begin
        if (hit) begin
          f_d   = i_q;
          cur_d = e;
          if (mode_q == MODE_ALLOC) begin
            if (split) begin
              if (i_nx < cnt_q) begin
                raddr_o = AW'(cnt_q - CNT_ONE);
                j_d     = cnt_q - CNT_ONE;
                state_d = S_UP;
              end else begin
                state_d = S_INS_A;
              end
            end else begin
              we_o    = 1'b1;
              waddr_o = i_q[AW-1:0];
              wdata_o = '{start: e.start, total: e.total, used: 1'b1};
              res_d   = '{status: STAT_OK, offset: e.start[OFW-1:0], granted: use_e};
              state_d = S_DONE;
            end
          end else begin
            if (i_nx < cnt_q) begin
              raddr_o = i_nx[AW-1:0];
              state_d = S_R_NX;
            end else begin
              nxf_d = 1'b0;
              if (i_q != '0) begin
                raddr_o = AW'(i_q - CNT_ONE);
                state_d = S_R_PV;
              end else begin
                pvf_d   = 1'b0;
                state_d = S_R_FIX;
              end
            end
          end
        end else if (i_nx < cnt_q) begin
          raddr_o = i_nx[AW-1:0];
          i_d     = i_nx;
        end else begin
          if (mode_q == MODE_ALLOC) begin
            res_d = '{status: STAT_NOSPACE, offset: '0, granted: '0};
          end else begin
            res_d = '{status: STAT_BADREL, offset: roff_q, granted: '0};
          end
          state_d = S_DONE;
        end
      end
      S_UP: begin
        we_o    = 1'b1;
        waddr_o = j_nx[AW-1:0];
        wdata_o = e;
        if (j_q > f_nx) begin
          raddr_o = AW'(j_q - CNT_ONE);
          j_d     = j_q - CNT_ONE;
        end else begin
          state_d = S_INS_A;
        end
      end
      S_INS_A: begin
        we_o    = 1'b1;
        waddr_o = f_nx[AW-1:0];
        wdata_o = '{start: cur_q.start + head, total: cur_q.total - head, used: 1'b0};
        state_d = S_INS_B;
      end
      S_INS_B: begin
        we_o    = 1'b1;
        waddr_o = f_q[AW-1:0];
        wdata_o = '{start: cur_q.start, total: head, used: 1'b1};
        cnt_d   = cnt_q + CNT_ONE;
        res_d   = '{status: STAT_OK, offset: cur_q.start[OFW-1:0], granted: SZW'(alloc_q)};
        state_d = S_DONE;
      end
      S_R_NX: begin
        nx_d  = e;
        nxf_d = !e.used;
        if (f_q != '0) begin
          raddr_o = f_pv[AW-1:0];
          state_d = S_R_PV;
        end else begin
          pvf_d   = 1'b0;
          state_d = S_R_FIX;
        end
      end
      S_R_PV: begin
        pv_d    = e;
        pvf_d   = !e.used;
        state_d = S_R_FIX;
      end
      S_R_FIX: begin
        res_d = '{status: STAT_OK, offset: roff_q, granted: '0};
        we_o  = 1'b1;
        if (!pvf_q) begin
          waddr_o = f_q[AW-1:0];
          wdata_o = '{start: cur_q.start,
                      total: nxf_q ? cur_q.total + nx_q.total : cur_q.total,
                      used: 1'b0};
          k_d = CNT_ONE;
          j_d = f_q + CNT_TWO;
        end else begin
          waddr_o = f_pv[AW-1:0];
          wdata_o = '{start: pv_q.start,
                      total: nxf_q ? pv_q.total + cur_q.total + nx_q.total
                                   : pv_q.total + cur_q.total,
                      used: 1'b0};
          k_d = nxf_q ? CNT_TWO : CNT_ONE;
          j_d = nxf_q ? f_q + CNT_TWO : f_nx;
        end
        if (!pvf_q && !nxf_q) begin
          state_d = S_DONE;
        end else if (j_d < cnt_q) begin
          raddr_o = j_d[AW-1:0];
          state_d = S_DN;
        end else begin
          cnt_d   = cnt_q - k_d;
          state_d = S_DONE;
        end
      end
      S_DN: begin
        we_o    = 1'b1;
        waddr_o = AW'(j_q - k_q);
        wdata_o = e;
        if (j_nx < cnt_q) begin
          raddr_o = j_nx[AW-1:0];
          j_d     = j_nx;
        end else begin
          cnt_d   = cnt_q - k_q;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (we_o && waddr_o == '0) begin
      init_d = 1'b0;
    end
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= CNT_ONE;
      init_q  <= 1'b1;
      rdz_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      init_q  <= init_d;
      rdz_q   <= (raddr_o == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    req_q   <= req_d;
    roff_q  <= roff_d;
    quo_q   <= quo_d;
    alloc_q <= alloc_d;
    i_q     <= i_d;
    f_q     <= f_d;
    j_q     <= j_d;
    k_q     <= k_d;
    cur_q   <= cur_d;
    nx_q    <= nx_d;
    pv_q    <= pv_d;
    nxf_q   <= nxf_d;
    pvf_q   <= pvf_d;
    res_q   <= res_d;
  end

endmodule

/* rtl/first_fit_coalescing_arena_allocator.sv */
// Top level: arena size register, sequencer, segment memory and result register.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  mode_i, request_bytes_i, release_offset_i
//   out      output     out_valid_o/out_stall_i status_o, segment_offset_o, granted_bytes_o
//   cfg      input      cfg_we_i               cfg_wdata_i (arena size)
//
// Allocate: rounds the request up to the alignment, scans the table; a split shifts later
// entries up and writes two entries. Release: scans, reads neighbours, writes the freed
// segment merged with free neighbours, shifting entries down. Flush, unused modes: no scan.
// Reset leaves one free segment spanning the arena; no clearing pass is needed.
// A new item is taken while a result waits in the output register.
module first_fit_coalescing_arena_allocator import ffca_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF,
  parameter int ARENA_BYTES  = ARENA_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [SZW-1:0] cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     mode_i,
  input  logic [SZW-1:0] request_bytes_i,
  input  logic [OFW-1:0] release_offset_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     status_o,
  output logic [OFW-1:0] segment_offset_o,
  output logic [SZW-1:0] granted_bytes_o
);

  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int RESET_ARENA = (ARENA_RESET > ARENA_BYTES) ? ARENA_BYTES : ARENA_RESET;

  logic [SZW-1:0] arena_q, arena_d;
  logic           ovalid_q;
  res_t           out_q;
  logic           idle;
  logic           in_go;
  logic           res_valid;
  logic           res_ready;
  res_t           res;
  logic           we;
  logic [AW-1:0]  waddr, raddr;
  ent_t           wdata, rdata;

  always_comb begin
    arena_d = cfg_wdata_i;
    if (32'(cfg_wdata_i) < 32'(ARENA_FLOOR)) begin
      arena_d = SZW'(ARENA_FLOOR);
    end else if (32'(cfg_wdata_i) > 32'(ARENA_BYTES)) begin
      arena_d = SZW'(ARENA_BYTES);
    end
  end

  assign in_stall_o = !idle;
  assign in_go      = in_valid_i && idle;
  assign res_ready  = !ovalid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q  <= SZW'(RESET_ARENA);
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        arena_q <= arena_d;
      end
      if (res_ready) begin
        ovalid_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = ovalid_q;
  assign status_o         = out_q.status;
  assign segment_offset_o = out_q.offset;
  assign granted_bytes_o  = out_q.granted;

  ffca_ctrl #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .HEADER_BYTES (HEADER_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES),
    .AW           (AW),
    .CW           (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_init_i  (cfg_we_i),
    .arena_i     (arena_q),
    .in_go_i     (in_go),
    .mode_i      (mode_i),
    .req_i       (request_bytes_i),
    .roff_i      (release_offset_i),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  ffca_mem #(
    .DEPTH (MAX_SEGMENTS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule
